### rtl/fpa_pkg.sv
// fpa_pkg: shared types, operation codes and status codes of the fixed-point alu
// no dependencies
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_GT   = 4'd4;
  localparam logic [3:0] OP_LT   = 4'd5;
  localparam logic [3:0] OP_GE   = 4'd6;
  localparam logic [3:0] OP_LE   = 4'd7;
  localparam logic [3:0] OP_EQ   = 4'd8;
  localparam logic [3:0] OP_NE   = 4'd9;
  localparam logic [3:0] OP_INC  = 4'd10;
  localparam logic [3:0] OP_DEC  = 4'd11;
  localparam logic [3:0] OP_MIN  = 4'd12;
  localparam logic [3:0] OP_MAX  = 4'd13;
  localparam logic [3:0] OP_FINT = 4'd14;
  localparam logic [3:0] OP_TINT = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [3:0]               mode;
    logic signed [DATA_W-1:0] a_raw;
    logic signed [DATA_W-1:0] b_raw;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_raw;
    logic                     flag;
    logic [1:0]               status;
  } out_word_t;

  // control and finished result that ride along the pipeline
  typedef struct packed {
    logic              vld;
    logic              is_div;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              flag;
    logic [1:0]        st;
  } side_t;

endpackage

### rtl/fpa_front.sv
// fpa_front: input register, operand decode, multiplier and multiply rounding
// depends on fpa_pkg
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           take,
  input  in_word_t                       word,
  output side_t                          side,
  output logic [DATA_W+FRAC_BITS+1:0]    n2,
  output logic [DATA_W:0]                d2
);
  localparam int N2W = DATA_W + FRAC_BITS + 2;
  localparam int PW  = 2 * DATA_W;

  // stage 1
  logic     v1;
  in_word_t w1;
  // stage 2
  side_t             s2;
  logic              is_mul2;
  logic [PW-1:0]     prod;
  logic [N2W-1:0]    n2_2;
  logic [DATA_W:0]   d2_2;

  logic [DATA_W-1:0] ma, mb;
  logic [DATA_W:0]   sum, dif, incv, decv;
  logic              lt_ab;
  side_t             s2_next;
  logic signed [DATA_W-1:0] a, b;
  logic [FRAC_BITS:0] top_bits;

  assign a = w1.a_raw;
  assign b = w1.b_raw;
  assign ma = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
  assign mb = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
  assign sum  = {a[DATA_W-1], a} + {b[DATA_W-1], b};
  assign dif  = {a[DATA_W-1], a} - {b[DATA_W-1], b};
  assign incv = {a[DATA_W-1], a} + (DATA_W+1)'(1);
  assign decv = {a[DATA_W-1], a} - (DATA_W+1)'(1);
  assign lt_ab = a < b;
  assign top_bits = a[DATA_W-1 -: FRAC_BITS+1];

  function automatic side_t sat33(input logic [DATA_W:0] v, input side_t s);
    side_t r;
    r = s;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r.res = v[DATA_W] ? VAL_MIN : VAL_MAX;
      r.st  = ST_OVF;
    end else begin
      r.res = v[DATA_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    s2_next        = '0;
    s2_next.vld    = v1;
    s2_next.neg    = a[DATA_W-1] ^ b[DATA_W-1];
    s2_next.st     = ST_OK;
    case (w1.mode)
      OP_ADD: s2_next = sat33(sum, s2_next);
      OP_SUB: s2_next = sat33(dif, s2_next);
      OP_MUL: ;
      OP_DIV: begin
        s2_next.is_div = 1'b1;
        if (b == '0) s2_next.st = ST_DIV0;
      end
      OP_GT:  s2_next.flag = a > b;
      OP_LT:  s2_next.flag = lt_ab;
      OP_GE:  s2_next.flag = a >= b;
      OP_LE:  s2_next.flag = a <= b;
      OP_EQ:  s2_next.flag = a == b;
      OP_NE:  s2_next.flag = a != b;
      OP_INC: s2_next = sat33(incv, s2_next);
      OP_DEC: s2_next = sat33(decv, s2_next);
      OP_MIN: s2_next.res = lt_ab ? a : b;
      OP_MAX: s2_next.res = lt_ab ? b : a;
      OP_FINT: begin
        // shift-in overflows unless the dropped bits match the sign
        if (top_bits != '0 && top_bits != '1) begin
          s2_next.res = a[DATA_W-1] ? VAL_MIN : VAL_MAX;
          s2_next.st  = ST_OVF;
        end else begin
          s2_next.res = a <<< FRAC_BITS;
        end
      end
      OP_TINT: s2_next.res = a >>> FRAC_BITS;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      s2.vld <= 1'b0;
    end else if (en) begin
      v1 <= take;
      if (take) w1 <= word;
      s2      <= s2_next;
      is_mul2 <= (w1.mode == OP_MUL);
      prod    <= ma * mb;
      n2_2    <= (N2W'(ma) << (FRAC_BITS + 1)) + N2W'(mb);
      d2_2    <= {mb, 1'b0};
    end
  end

  // stage 3: round the product half away from zero and saturate
  logic [PW-1:0] q;
  logic          big;
  side_t         s3_next;

  assign q   = (prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign big = s2.neg ? (q > PW'(VAL_MIN) & (q >> DATA_W) == '0 ? 1'b1 : q > {1'b0, VAL_MIN})
                      : (q > PW'(VAL_MAX));

  always_comb begin
    s3_next = s2;
    if (is_mul2) begin
      if (big) begin
        s3_next.res = s2.neg ? VAL_MIN : VAL_MAX;
        s3_next.st  = ST_OVF;
      end else begin
        s3_next.res = s2.neg ? DATA_W'(-q[DATA_W-1:0]) : q[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.vld <= 1'b0;
    end else if (en) begin
      side <= s3_next;
      n2   <= n2_2;
      d2   <= d2_2;
    end
  end

endmodule

### rtl/fpa_div_cell.sv
// fpa_div_cell: one restoring-division step, one quotient bit per cell
// depends on fpa_pkg
module fpa_div_cell import fpa_pkg::*; #(
  parameter int N2W = DATA_W + FRAC_BITS_DEF + 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  side_t             side_i,
  input  logic [DATA_W:0]   rem_i,
  input  logic [N2W-1:0]    nq_i,
  input  logic [DATA_W:0]   d2_i,
  output side_t             side_o,
  output logic [DATA_W:0]   rem_o,
  output logic [N2W-1:0]    nq_o,
  output logic [DATA_W:0]   d2_o
);
  logic [DATA_W+1:0] rs, diff;
  logic              ge;

  assign rs   = {rem_i, nq_i[N2W-1]};
  assign diff = rs - {1'b0, d2_i};
  assign ge   = rs >= {1'b0, d2_i};

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o.vld <= 1'b0;
    end else if (en) begin
      side_o <= side_i;
      rem_o  <= ge ? diff[DATA_W:0] : rs[DATA_W:0];
      nq_o   <= {nq_i[N2W-2:0], ge};
      d2_o   <= d2_i;
    end
  end

endmodule

### rtl/fixed_point_alu_unit.sv
// fixed_point_alu_unit: top level of the q24.8 fixed-point alu
// depends on fpa_pkg, fpa_front, fpa_div_cell
//
//  channel | direction | handshake           | word
//  in      | input     | in_valid / in_stall  | in_word_t (mode, a_raw, b_raw)
//  out     | output    | out_valid / out_stall| out_word_t (result_raw, flag, status)
//
// one word per cycle in steady state unless the output word is held
// a word passes the input register, the front stages, the chain of division
// cells, one quotient bit each, and the output register
// every operation takes the same path so words leave in order
// rst is synchronous and clears all valid bits
// a held output word stalls the whole pipeline, and in_stall follows
module fixed_point_alu_unit import fpa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  // quotient width of (2*num*2^FRAC_BITS + den) / (2*den)
  localparam int N2W = DATA_W + FRAC_BITS + 2;

  logic en;

  // pipeline advances unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  side_t             sd   [N2W+1];
  logic [DATA_W:0]   rem  [N2W+1];
  logic [N2W-1:0]    nq   [N2W+1];
  logic [DATA_W:0]   d2   [N2W+1];

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .take (in_valid),
    .word (in_word),
    .side (sd[0]),
    .n2   (nq[0]),
    .d2   (d2[0])
  );
  // partial remainder starts empty
  assign rem[0] = '0;

  // division chain, one cell per quotient bit
  for (genvar i = 0; i < N2W; i++) begin : g_cell
    fpa_div_cell #(.N2W(N2W)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .side_i (sd[i]),
      .rem_i  (rem[i]),
      .nq_i   (nq[i]),
      .d2_i   (d2[i]),
      .side_o (sd[i+1]),
      .rem_o  (rem[i+1]),
      .nq_o   (nq[i+1]),
      .d2_o   (d2[i+1])
    );
  end

  // final stage: sign and saturation of the quotient
  side_t          s;
  logic [N2W-1:0] q;
  logic           big;
  out_word_t      o_next;

  assign s   = sd[N2W];
  assign q   = nq[N2W];
  assign big = s.neg ? (q > N2W'({1'b0, VAL_MIN})) : (q > N2W'(VAL_MAX));

  always_comb begin
    o_next.result_raw = s.res;
    o_next.flag       = s.flag;
    o_next.status     = s.st;
    if (s.is_div) begin
      if (s.st == ST_DIV0) begin
        o_next.result_raw = '0;
      end else if (big) begin
        o_next.result_raw = s.neg ? VAL_MIN : VAL_MAX;
        o_next.status     = ST_OVF;
      end else begin
        o_next.result_raw = s.neg ? DATA_W'(-q[DATA_W-1:0]) : q[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s.vld;
      out_word  <= o_next;
    end
  end

endmodule

### rtl/fpa_checker.sv
// fpa_checker: port-level assertions for fixed_point_alu_unit, with its bind
// depends on fpa_pkg
module fpa_checker import fpa_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);
  // a held word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("out word dropped");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.status != 2'd3) else $error("bad status");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.flag |-> out_word.status == ST_OK && out_word.result_raw == '0)
    else $error("flag with nonzero result");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status == ST_DIV0 |-> out_word.result_raw == '0 && !out_word.flag)
    else $error("divide by zero result not cleared");

endmodule

bind fixed_point_alu_unit fpa_checker u_fpa_checker (.*);
